// File: sv/frv_pkg.sv
package frv_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int FL_W       = 11;
   localparam int HOP_W      = 13;
   localparam int THR_W      = 16;
   localparam int SUM_W      = 41;
   localparam int SEEN_W     = 32;
   localparam int START_W    = 32;
   localparam int CD_W       = 12;
   localparam int SQ_W       = 31;
   localparam int RMS_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int HOP_MAX    = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_LEN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VAD_THRESHOLD = 2'd2;

   localparam logic [FL_W-1:0]  FRAME_LEN_RST = 11'd1024;
   localparam logic [HOP_W-1:0] HOP_LEN_RST   = 13'd512;
   localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd655;

   // Square of a signed Q1.15 sample; at most 2^30.
   function automatic logic [SQ_W-1:0] square_of(input logic signed [SAMPLE_W-1:0] v);
      logic signed [2*SAMPLE_W-1:0] p;
      p = v * v;
      return p[SQ_W-1:0];
   endfunction

endpackage

// File: sv/frv_req_if.sv
interface frv_req_if;
   import frv_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

// File: sv/frv_rsp_if.sv
interface frv_rsp_if;
   import frv_pkg::*;

   logic               valid;
   logic               ready;
   logic [START_W-1:0] frame_start;
   logic [RMS_W-1:0]   rms;
   logic               is_voice;

   modport source (output valid, output frame_start, output rms, output is_voice, input ready);
   modport sink   (input valid, input frame_start, input rms, input is_voice, output ready);
endinterface

// File: sv/frv_ram.sv
module frv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic              read_enable,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

// File: sv/framed_rms_voice_detector_unit.sv
// Sample without a frame end: accepted in idle, window sum updated in the next cycle;
// no new sample is taken until that update is done (delay-line read before the sum update).
// Frame end: sum update, then a 41-step divide by frame_len and a 16-step square root;
// the next sample is taken once the result is registered (this waits for an unaccepted prior result).
// Synchronous active-high reset clears the control registers, counters and the window sum;
// the delay-line memory is not cleared, only entries written since restart are used.
module framed_rms_voice_detector_unit #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [frv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [frv_pkg::CSR_DATA_W-1:0] csr_write_data,
   frv_req_if.sink                         req_ch,
   frv_rsp_if.source                       rsp_ch
);
   import frv_pkg::*;

   localparam int ADDR_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int PW     = ((ADDR_W > FL_W) ? ADDR_W : FL_W) + 2;
   localparam int STEP_W = 6;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   function automatic logic [FL_W-1:0] eff_frame(input logic [FL_W-1:0] f);
      if (f == '0) return FL_W'(1);
      else if (32'(f) > MAX_FRAME) return FL_W'(MAX_FRAME);
      else return f;
   endfunction

   function automatic logic [HOP_W-1:0] eff_hop(input logic [HOP_W-1:0] h);
      if (h == '0) return HOP_W'(1);
      else if (32'(h) > HOP_MAX) return HOP_W'(HOP_MAX);
      else return h;
   endfunction

   // control state
   logic [2:0]          state_ff, state_in;
   logic [FL_W-1:0]     frame_len_ff, frame_len_in;
   logic [HOP_W-1:0]    hop_len_ff, hop_len_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic [CD_W-1:0]     cd_ff, cd_in;
   logic [START_W-1:0]  ns_ff, ns_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SQ_W-1:0]     sq_new_ff, sq_new_in;
   logic                sub_ff, sub_in;
   logic                frame_end_ff, frame_end_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [START_W-1:0]  start_ff, start_in;
   logic [FL_W-1:0]     fl_ff, fl_in;
   logic [SUM_W-1:0]    div_q_ff, div_q_in;
   logic [FL_W-1:0]     div_r_ff, div_r_in;
   logic [31:0]         sq_x_ff, sq_x_in;
   logic [17:0]         sq_rem_ff, sq_rem_in;
   logic [RMS_W-1:0]    sq_root_ff, sq_root_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [RMS_W-1:0]    rsp_rms_ff, rsp_rms_in;
   logic                rsp_voice_ff, rsp_voice_in;

   // datapath
   logic                accept;
   logic                restart;
   logic [FL_W-1:0]     fl;
   logic [HOP_W-1:0]    hop;
   logic [ADDR_W-1:0]   wp_eff;
   logic [SEEN_W-1:0]   seen_eff;
   logic [CD_W-1:0]     cd_eff;
   logic [START_W-1:0]  ns_eff;
   logic [PW-1:0]       wp_ext, fl_ext, rd_ext, wp_inc;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SUM_W-1:0]    sum_next;
   logic [FL_W:0]       div_sh, div_sub;
   logic                div_ge;
   logic [SUM_W-1:0]    div_q_next;
   logic [19:0]         sq_sh, sq_trial, sq_sub;
   logic                sq_ge;
   logic                rsp_load;

   assign accept  = req_ch.valid && req_ch.ready;
   assign restart = req_ch.restart;
   assign fl      = eff_frame(frame_len_ff);
   assign hop     = eff_hop(hop_len_ff);

   assign wp_eff   = restart ? '0 : wp_ff;
   assign seen_eff = restart ? '0 : seen_ff;
   assign cd_eff   = restart ? CD_W'(fl - 1'b1) : cd_ff;
   assign ns_eff   = restart ? '0 : ns_ff;

   // oldest window entry: write position minus frame length, modulo the delay-line depth
   assign wp_ext  = PW'(wp_eff);
   assign fl_ext  = PW'(fl);
   assign rd_ext  = (wp_ext >= fl_ext) ? wp_ext - fl_ext : wp_ext + PW'(MAX_FRAME) - fl_ext;
   assign rd_addr = rd_ext[ADDR_W-1:0];
   assign wp_inc  = wp_ext + PW'(1);

   assign sum_next = sum_ff + SUM_W'(sq_new_ff)
                     - (sub_ff ? SUM_W'(square_of($signed(ram_rdata))) : '0);

   // restoring divide, one quotient bit a cycle
   assign div_sh     = {div_r_ff, div_q_ff[SUM_W-1]};
   assign div_ge     = div_sh >= {1'b0, fl_ff};
   assign div_sub    = div_sh - {1'b0, fl_ff};
   assign div_q_next = {div_q_ff[SUM_W-2:0], div_ge};

   // digit-by-digit square root, one result bit a cycle
   assign sq_sh    = {sq_rem_ff, sq_x_ff[31:30]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge    = sq_sh >= sq_trial;
   assign sq_sub   = sq_sh - sq_trial;

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   frv_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_FRAME)
   ) u_history (
      .clock        (clock),
      .write_enable (state_ff == S_UPD),
      .write_addr   (wr_addr_ff),
      .write_data   (sample_ff),
      .read_enable  (accept),
      .read_addr    (rd_addr),
      .read_data    (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      frame_len_in  = frame_len_ff;
      hop_len_in    = hop_len_ff;
      thr_in        = thr_ff;
      sum_in        = sum_ff;
      seen_in       = seen_ff;
      cd_in         = cd_ff;
      ns_in         = ns_ff;
      wp_in         = wp_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      sample_in     = sample_ff;
      sq_new_in     = sq_new_ff;
      sub_in        = sub_ff;
      frame_end_in  = frame_end_ff;
      wr_addr_in    = wr_addr_ff;
      start_in      = start_ff;
      fl_in         = fl_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      sq_x_in       = sq_x_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_rms_in    = rsp_rms_ff;
      rsp_voice_in  = rsp_voice_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sample_in  = req_ch.sample;
               sq_new_in  = square_of(req_ch.sample);
               sub_in     = seen_eff >= SEEN_W'(fl);
               wr_addr_in = wp_eff;
               fl_in      = fl;
               sum_in     = restart ? '0 : sum_ff;
               wp_in      = (wp_inc >= PW'(MAX_FRAME)) ? '0 : wp_inc[ADDR_W-1:0];
               seen_in    = (seen_eff == '1) ? seen_eff : seen_eff + 1'b1;
               if (cd_eff != '0) begin
                  cd_in        = cd_eff - 1'b1;
                  ns_in        = ns_eff;
                  frame_end_in = 1'b0;
               end else begin
                  cd_in        = CD_W'(hop - 1'b1);
                  start_in     = ns_eff;
                  ns_in        = ns_eff + START_W'(hop);
                  frame_end_in = 1'b1;
               end
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            sum_in = sum_next;
            if (frame_end_ff) begin
               div_q_in = sum_next;
               div_r_in = '0;
               step_in  = STEP_W'(SUM_W - 1);
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            div_q_in = div_q_next;
            div_r_in = div_ge ? div_sub[FL_W-1:0] : div_sh[FL_W-1:0];
            if (step_ff == '0) begin
               // mean square is at most 2^30
               sq_x_in    = div_q_next[31:0];
               sq_rem_in  = '0;
               sq_root_in = '0;
               step_in    = STEP_W'(RMS_W - 1);
               state_in   = S_SQRT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_SQRT: begin
            sq_x_in    = {sq_x_ff[29:0], 2'b00};
            sq_rem_in  = sq_ge ? sq_sub[17:0] : sq_sh[17:0];
            sq_root_in = {sq_root_ff[RMS_W-2:0], sq_ge};
            if (step_ff == '0) begin
               state_in = S_OUT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = start_ff;
               rsp_rms_in   = sq_root_ff;
               rsp_voice_in = sq_root_ff >= thr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // frame or hop length write restarts the stream
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_LEN: begin
               frame_len_in = csr_write_data[FL_W-1:0];
               sum_in       = '0;
               seen_in      = '0;
               ns_in        = '0;
               wp_in        = '0;
               cd_in        = CD_W'(eff_frame(csr_write_data[FL_W-1:0]) - 1'b1);
            end
            CSR_HOP_LEN: begin
               hop_len_in = csr_write_data[HOP_W-1:0];
               sum_in     = '0;
               seen_in    = '0;
               ns_in      = '0;
               wp_in      = '0;
               cd_in      = CD_W'(fl - 1'b1);
            end
            CSR_VAD_THRESHOLD: begin
               thr_in = csr_write_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         frame_len_ff <= FRAME_LEN_RST;
         hop_len_ff   <= HOP_LEN_RST;
         thr_ff       <= THRESHOLD_RST;
         sum_ff       <= '0;
         seen_ff      <= '0;
         cd_ff        <= CD_W'(eff_frame(FRAME_LEN_RST) - 1'b1);
         ns_ff        <= '0;
         wp_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_len_ff <= frame_len_in;
         hop_len_ff   <= hop_len_in;
         thr_ff       <= thr_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         cd_ff        <= cd_in;
         ns_ff        <= ns_in;
         wp_ff        <= wp_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      sq_new_ff    <= sq_new_in;
      sub_ff       <= sub_in;
      frame_end_ff <= frame_end_in;
      wr_addr_ff   <= wr_addr_in;
      start_ff     <= start_in;
      fl_ff        <= fl_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      sq_x_ff      <= sq_x_in;
      sq_rem_ff    <= sq_rem_in;
      sq_root_ff   <= sq_root_in;
      rsp_start_ff <= rsp_start_in;
      rsp_rms_ff   <= rsp_rms_in;
      rsp_voice_ff <= rsp_voice_in;
   end

   assign req_ch.ready       = state_ff == S_IDLE;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.frame_start = rsp_start_ff;
   assign rsp_ch.rms         = rsp_rms_ff;
   assign rsp_ch.is_voice    = rsp_voice_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff == S_UPD)
      else $error("transaction accepted but window update skipped");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside output state");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_rms_ff <= 16'd32768)
      else $error("rms out of range");

   a_div_to_sqrt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == '0) |=> state_ff == S_SQRT)
      else $error("divide did not hand over to square root");
`endif
endmodule
